// ===== rtl/assert_macros.svh =====
// assertion macros shared by the option header decoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property does not hold");

// same-cycle implication checked on every clock edge out of reset
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication does not hold");

`endif

// ===== rtl/ohd_pkg.sv =====
// types, constants and nibble helpers for the option header decoder
// no dependencies; imported by the front, back and top level
`timescale 1ns / 1ps

package ohd_pkg;

  // nibble codes that call for extension bytes
  localparam logic [3:0]  NibExt1 = 4'd13;
  localparam logic [3:0]  NibExt2 = 4'd14;
  // offsets added to the extension bytes
  localparam logic [16:0] OfsExt1 = 17'd13;
  localparam logic [16:0] OfsExt2 = 17'd269;

  // command from the front to the back, one per accepted byte
  typedef struct packed {
    logic       is_hdr;     // first byte of a header
    logic       to_length;  // extension byte belongs to the length
    logic       hi_byte;    // extension byte weighs 256
    logic       done;       // header complete after this byte
    logic [7:0] data;
  } cmd_t;

  // decoded header as delivered
  typedef struct packed {
    logic [16:0] delta;
    logic [16:0] length;
    logic [2:0]  size;
  } result_t;

  // extension bytes that follow a nibble
  function automatic logic [1:0] nib_ext_bytes(input logic [3:0] nib);
    logic [1:0] n;
    case (nib)
      NibExt1: n = 2'd1;
      NibExt2: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // starting value for a nibble: the offset, or the nibble itself
  function automatic logic [16:0] nib_start_value(input logic [3:0] nib);
    logic [16:0] v;
    case (nib)
      NibExt1: v = OfsExt1;
      NibExt2: v = OfsExt2;
      default: v = {13'd0, nib};
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ohd_fifo.sv =====
// small first-in first-out queue with a register array
// no dependencies; used between front and back and at the result side
`timescale 1ns / 1ps

module ohd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/ohd_front.sv =====
// front of the option header decoder: tracks header phase, classifies bytes
// depends on ohd_pkg; feeds commands into the queue toward the back
`timescale 1ns / 1ps

module ohd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          start_req_i,
  output ohd_pkg::cmd_t cmd_o
);
  import ohd_pkg::*;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhDelta  = 2'd1;
  localparam logic [1:0] PhLength = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [1:0] left_q, left_d;
  logic [3:0] pend_q, pend_d;
  logic [1:0] dl, ll, pl, left_dec;

  assign dl       = nib_ext_bytes(data_byte_i[7:4]);
  assign ll       = nib_ext_bytes(data_byte_i[3:0]);
  assign pl       = nib_ext_bytes(pend_q);
  assign left_dec = (left_q != 2'd0) ? left_q - 2'd1 : 2'd0;

  // classify the byte and advance the phase
  always_comb begin
    phase_d         = phase_q;
    left_d          = left_q;
    pend_d          = pend_q;
    cmd_o.data      = data_byte_i;
    cmd_o.is_hdr    = 1'b0;
    cmd_o.to_length = (phase_q == PhLength);
    cmd_o.hi_byte   = (left_q >= 2'd2);
    cmd_o.done      = 1'b0;
    if (start_req_i || ((phase_q != PhDelta) && (phase_q != PhLength))) begin
      cmd_o.is_hdr = 1'b1;
      pend_d       = data_byte_i[3:0];
      if (dl != 2'd0) begin
        phase_d = PhDelta;
        left_d  = dl;
      end else if (ll != 2'd0) begin
        phase_d = PhLength;
        left_d  = ll;
      end else begin
        phase_d    = PhIdle;
        left_d     = 2'd0;
        cmd_o.done = 1'b1;
      end
    end else begin
      left_d = left_dec;
      if (left_dec == 2'd0) begin
        if ((phase_q == PhDelta) && (pl != 2'd0)) begin
          phase_d = PhLength;
          left_d  = pl;
        end else begin
          phase_d    = PhIdle;
          cmd_o.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      left_q  <= 2'd0;
      pend_q  <= 4'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ===== rtl/ohd_back.sv =====
// back of the option header decoder: accumulates delta, length and size
// depends on ohd_pkg; takes commands from the queue, writes results out
`timescale 1ns / 1ps

module ohd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  ohd_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output ohd_pkg::result_t res_o
);
  import ohd_pkg::*;

  logic [16:0] delta_q, delta_d;
  logic [16:0] length_q, length_d;
  logic [2:0]  size_q, size_d;
  logic [16:0] add;

  assign cmd_pop_o  = !cmd_empty_i && !res_full_i;
  assign res_push_o = cmd_pop_o && cmd_i.done;
  assign add = cmd_i.hi_byte ? {1'b0, cmd_i.data, 8'h00} : {9'd0, cmd_i.data};

  // accumulate the current transaction
  always_comb begin
    delta_d  = delta_q;
    length_d = length_q;
    size_d   = size_q;
    if (cmd_i.is_hdr) begin
      delta_d  = nib_start_value(cmd_i.data[7:4]);
      length_d = nib_start_value(cmd_i.data[3:0]);
      size_d   = 3'd1;
    end else begin
      size_d = size_q + 3'd1;
      if (cmd_i.to_length) begin
        length_d = length_q + add;
      end else begin
        delta_d = delta_q + add;
      end
    end
  end

  assign res_o.delta  = delta_d;
  assign res_o.length = length_d;
  assign res_o.size   = size_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q  <= '0;
      length_q <= '0;
      size_q   <= '0;
    end else if (cmd_pop_o) begin
      delta_q  <= delta_d;
      length_q <= length_d;
      size_q   <= size_d;
    end
  end

endmodule

// ===== rtl/option_header_decoder.sv =====
// top level of the option header decoder: front, command queue, back, result queue
// depends on ohd_pkg, ohd_fifo, ohd_front, ohd_back and assert_macros.svh
`timescale 1ns / 1ps

// Decodes a CoAP-style option header fed one byte per transaction on the
// push side and delivers delta, length and header size on the pop side once
// a header is complete. One byte is taken every cycle while the command queue
// is not full; nothing iterates. A result reaches the outputs through the
// command queue, which holds its last byte, and the back, which adds that
// byte in without a register of its own, straight into the result queue. The
// queue depths set how long either side may stall before the other one sees
// it.
module option_header_decoder #(
  parameter int CmdDepth = 2,
  parameter int ResDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  output logic        empty,
  input  logic        pop,
  output logic [16:0] option_delta_o,
  output logic [16:0] option_length_o,
  output logic [2:0]  header_size_o
);
  import ohd_pkg::*;

  `include "assert_macros.svh"

  cmd_t    cmd_in, cmd_out;
  result_t res_in, res_out;
  logic    accept, cmd_empty, cmd_pop, res_full, res_push;

  assign accept = push && !full;

  // byte classification
  ohd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .start_req_i (start_req_i),
    .cmd_o       (cmd_in)
  );

  // queue between front and back
  ohd_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // accumulation
  ohd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue
  ohd_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign option_delta_o  = res_out.delta;
  assign option_length_o = res_out.length;
  assign header_size_o   = res_out.size;

  // checks on the internal flow
  `ASSERT_IMPLIES(a_no_pop_when_res_full, clk_i, rst_ni, res_full, !cmd_pop)
  `ASSERT_IMPLIES(a_res_push_from_cmd, clk_i, rst_ni, res_push, cmd_pop && cmd_out.done)
  `ASSERT_IMPLIES(a_size_in_range, clk_i, rst_ni, !empty,
                  header_size_o >= 3'd1 && header_size_o <= 3'd5)
  `ASSERT_IMPLIES(a_hdr_restarts_size, clk_i, rst_ni, cmd_pop && cmd_out.is_hdr,
                  res_in.size == 3'd1)

endmodule

// ===== tb/sv/tb_option_header_decoder.sv =====
// self-checking testbench for the option header decoder: a header tracker
// predicts decoded delta, length and size per accepted byte; needs ohd_pkg
// and the option_header_decoder rtl, nothing else
`timescale 1ns / 1ps

module tb_option_header_decoder;
  import ohd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 10;
  localparam int HoldCycles  = 300;
  localparam logic [3:0] NibPlain15 = 4'd15;

  // where the decoder stands in a header
  typedef enum logic [1:0] {
    WaitHeader,
    DeltaExt,
    LengthExt
  } dec_phase_e;

  // tracks the header state and holds decoded headers still to come out
  class header_tracker;
    dec_phase_e  phase;
    logic [3:0]  len_nib;
    logic [1:0]  ext_left;
    logic [16:0] delta_acc;
    logic [16:0] length_acc;
    logic [2:0]  nbytes;
    result_t     expected_headers[$];
    int          errors;

    function new();
      phase      = WaitHeader;
      len_nib    = '0;
      ext_left   = '0;
      delta_acc  = '0;
      length_acc = '0;
      nbytes     = '0;
      errors     = 0;
    endfunction

    // extension byte count and starting value for one nibble
    function void nibble_setup(input logic [3:0] nib, output logic [1:0] n,
                               output logic [16:0] v);
      if (nib == NibExt1) begin
        n = 2'd1;
        v = OfsExt1;
      end else if (nib == NibExt2) begin
        n = 2'd2;
        v = OfsExt2;
      end else begin
        n = 2'd0;
        v = {13'd0, nib};
      end
    endfunction

    function void finish_header();
      expected_headers.push_back(result_t'{delta: delta_acc, length: length_acc,
                                           size: nbytes});
      phase    = WaitHeader;
      ext_left = '0;
    endfunction

    function void start_length();
      logic [1:0] n;
      nibble_setup(len_nib, n, length_acc);
      if (n == 2'd0) begin
        finish_header();
      end else begin
        ext_left = n;
        phase    = LengthExt;
      end
    endfunction

    // one accepted byte transaction
    function void take_byte(input logic [7:0] b, input logic s);
      logic [1:0]  n;
      logic [16:0] add;
      if (s || phase == WaitHeader) begin
        nbytes     = 3'd1;
        len_nib    = b[3:0];
        length_acc = '0;
        nibble_setup(b[7:4], n, delta_acc);
        if (n == 2'd0) begin
          start_length();
        end else begin
          ext_left = n;
          phase    = DeltaExt;
        end
      end else begin
        // extension bytes are big-endian
        nbytes   = nbytes + 3'd1;
        add      = (ext_left >= 2'd2) ? {1'b0, b, 8'h00} : {9'd0, b};
        ext_left = (ext_left > 2'd0) ? ext_left - 2'd1 : 2'd0;
        if (phase == DeltaExt) begin
          delta_acc = delta_acc + add;
          if (ext_left == 2'd0) start_length();
        end else begin
          length_acc = length_acc + add;
          if (ext_left == 2'd0) finish_header();
        end
      end
    endfunction

    // compare one popped result with the oldest decoded header
    function void check_header(input logic [16:0] d, input logic [16:0] l,
                               input logic [2:0] sz);
      result_t exp_hdr;
      if (expected_headers.size() == 0) begin
        errors++;
        $error("result with no header pending: delta %0d length %0d size %0d",
               d, l, sz);
        return;
      end
      exp_hdr = expected_headers.pop_front();
      if (d !== exp_hdr.delta) begin
        errors++;
        $error("option_delta: expected %0d, actual %0d", exp_hdr.delta, d);
      end
      if (l !== exp_hdr.length) begin
        errors++;
        $error("option_length: expected %0d, actual %0d", exp_hdr.length, l);
      end
      if (sz !== exp_hdr.size) begin
        errors++;
        $error("header_size: expected %0d, actual %0d", exp_hdr.size, sz);
      end
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        start_req_i;
  logic        empty;
  logic        pop;
  logic [16:0] option_delta_o;
  logic [16:0] option_length_o;
  logic [2:0]  header_size_o;

  header_tracker tracker;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  n_sent;
  int  cycles;
  bit  hold_done;
  bit  force_start;

  option_header_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .start_req_i    (start_req_i),
    .empty          (empty),
    .pop            (pop),
    .option_delta_o (option_delta_o),
    .option_length_o(option_length_o),
    .header_size_o  (header_size_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // extension bytes that follow a nibble
  function automatic int ext_count(input logic [3:0] nib);
    if (nib == NibExt1) return 1;
    if (nib == NibExt2) return 2;
    return 0;
  endfunction

  // nibble mix that favors the extension codes and fifteen
  function automatic logic [3:0] pick_nibble();
    case ($urandom_range(0, 5))
      0: return NibExt1;
      1: return NibExt2;
      2: return NibPlain15;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // offer one byte, with random idle cycles first; returns once accepted
  task automatic send_byte(input logic [7:0] b, input logic s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push        = 1'b1;
    data_byte_i = b;
    start_req_i = s;
    do @(posedge clk_i); while (full);
    tracker.take_byte(b, s);
    n_sent++;
  endtask

  // one header with random content, sometimes cut short
  task automatic send_header();
    logic [3:0] dn;
    logic [3:0] ln;
    logic [7:0] hdr_bytes[$];
    logic       s;
    int         n_ext;
    dn    = pick_nibble();
    ln    = pick_nibble();
    n_ext = ext_count(dn) + ext_count(ln);
    hdr_bytes.push_back({dn, ln});
    repeat (n_ext) hdr_bytes.push_back(8'($urandom_range(0, 255)));
    s           = force_start ? 1'b1 : 1'($urandom_range(0, 1));
    force_start = 1'b0;
    // broken header: drop the tail, next header must force a start
    if (n_ext > 0 && $urandom_range(0, 9) == 0) begin
      while (hdr_bytes.size() > $urandom_range(1, n_ext)) void'(hdr_bytes.pop_back());
      force_start = 1'b1;
    end
    foreach (hdr_bytes[i]) send_byte(hdr_bytes[i], (i == 0) ? s : 1'b0);
  endtask

  // result side: random pops, one long hold-off, checks at the rising edge
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    pop      = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        pop = 1'b0;
        hold_cnt--;
      end else if (!hold_done && n_sent >= 1350) begin
        hold_done = 1'b1;
        hold_cnt  = HoldCycles;
        pop       = 1'b0;
      end else begin
        pop = ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk_i);
      if (pop && !empty) tracker.check_header(option_delta_o, option_length_o, header_size_o);
    end
  end

  // stimulus
  initial begin
    bit paused;
    tracker       = new();
    paused        = 1'b0;
    hold_done     = 1'b0;
    force_start   = 1'b0;
    n_sent        = 0;
    cycles        = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push          = 1'b0;
    data_byte_i   = '0;
    start_req_i   = 1'b0;
    rst_ni        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: plain nibbles, start while waiting
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC5, 1'b0);
    // one and two byte extensions at both ends
    send_byte(8'hD0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hEE, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b0);
    // start mid-header in the delta part, then in the length part
    send_byte(8'hE1, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h21, 1'b1);
    send_byte(8'hDD, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h30, 1'b1);

    // random headers with some noise bytes
    while (n_sent < 1775) begin
      if (n_sent < 600) begin
        send_idle_pct = 25;
        recv_idle_pct = 65;
      end else if (n_sent < 1200) begin
        send_idle_pct = 65;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // sender pause until every decoded header has been popped
      if (!paused && n_sent >= 1550) begin
        paused = 1'b1;
        @(negedge clk_i);
        push = 1'b0;
        while (tracker.pending() > 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 19) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        force_start = 1'b1;
      end else begin
        send_header();
      end
    end

    // drain
    @(negedge clk_i);
    push          = 1'b0;
    recv_idle_pct = 0;
    while (tracker.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
